// File: src/lirs_pkg.sv
package lirs_pkg;

  // Sample grid and read position formats.
  localparam int SAMPLE_WIDTH = 24;
  localparam int STEP_W       = 21;
  localparam int POS_W        = 22;
  localparam int FRAC_W       = 16;
  localparam int ONE_Q16      = 65536;

  // Depths of the two queues.
  localparam int JOB_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           final_sample;
  } lirs_in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           holds_sample;
    logic                           run_last;
    logic                           stream_end;
  } lirs_out_t;

  typedef enum logic [1:0] {
    JOB_PASS,
    JOB_INTERP,
    JOB_MARK
  } job_kind_t;

  // One unit of work handed from the front end to the back end.
  typedef struct packed {
    job_kind_t                      kind;
    logic signed [SAMPLE_WIDTH-1:0] y1;
    logic signed [SAMPLE_WIDTH-1:0] y2;
    logic [STEP_W-1:0]              eff;
    logic                           fin;
  } lirs_job_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

// File: src/lirs_fifo.sv
module lirs_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  T                           wr_data,
  output logic                       full,
  input  logic                       rd_en,
  output T                           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  T                mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = mem[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: src/lirs_front.sv
module lirs_front #(
  parameter int MAX_OUTPUTS_PER_INPUT = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  lirs_pkg::lirs_in_t                  in_data,
  output logic                                full,
  input  logic                                cfg_wr_en,
  input  logic [lirs_pkg::STEP_W-1:0]         cfg_wr_data,
  output logic                                job_push,
  output lirs_pkg::lirs_job_t                 job,
  input  logic                                job_full
);

  localparam int MIN_STEP =
    (lirs_pkg::ONE_Q16 + MAX_OUTPUTS_PER_INPUT - 1) / MAX_OUTPUTS_PER_INPUT;

  logic [lirs_pkg::STEP_W-1:0]               step_r;
  logic signed [lirs_pkg::SAMPLE_WIDTH-1:0]  prior_r, prior_nxt;
  logic                                      have_r, have_nxt;
  logic [lirs_pkg::STEP_W-1:0]               eff;
  logic                                      accept;

  assign full   = job_full;
  assign accept = push && !job_full;
  assign eff    = (step_r < lirs_pkg::STEP_W'(MIN_STEP)) ?
                  lirs_pkg::STEP_W'(MIN_STEP) : step_r;

  // Classify the incoming sample and update the stored neighbor.
  always_comb begin
    job_push  = 1'b0;
    job.kind  = lirs_pkg::JOB_INTERP;
    job.y1    = prior_r;
    job.y2    = in_data.sample_in;
    job.eff   = eff;
    job.fin   = in_data.final_sample;
    prior_nxt = prior_r;
    have_nxt  = have_r;
    if (accept) begin
      prior_nxt = in_data.sample_in;
      have_nxt  = 1'b1;
      if (step_r == lirs_pkg::STEP_W'(lirs_pkg::ONE_Q16)) begin
        job_push = 1'b1;
        job.kind = lirs_pkg::JOB_PASS;
      end else if (have_r) begin
        job_push = 1'b1;
        job.kind = lirs_pkg::JOB_INTERP;
      end else begin
        job_push = in_data.final_sample;
        job.kind = lirs_pkg::JOB_MARK;
      end
      if (in_data.final_sample) begin
        prior_nxt = '0;
        have_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= lirs_pkg::STEP_W'(lirs_pkg::ONE_Q16);
      prior_r <= '0;
      have_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        step_r <= cfg_wr_data;
      end
      prior_r <= prior_nxt;
      have_r  <= have_nxt;
    end
  end

endmodule

// File: src/lirs_back.sv
module lirs_back #(
  parameter int MAX_OUTPUTS_PER_INPUT = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  lirs_pkg::lirs_job_t                           job,
  input  logic                                          job_empty,
  output logic                                          job_pop,
  input  logic [$clog2(lirs_pkg::OUT_DEPTH+1)-1:0]      res_cnt,
  output logic                                          res_push,
  output lirs_pkg::lirs_out_t                           res
);

  localparam int SW   = lirs_pkg::SAMPLE_WIDTH;
  localparam int DW   = SW + 1;
  localparam int PW   = DW + lirs_pkg::FRAC_W + 1;
  localparam int QW   = PW - lirs_pkg::FRAC_W;
  localparam int YW   = SW + 3;
  localparam int CW   = $clog2(lirs_pkg::OUT_DEPTH + 1) + 1;
  localparam int NW   = $clog2(MAX_OUTPUTS_PER_INPUT + 1);
  localparam int POSW = lirs_pkg::POS_W;
  localparam int STW  = lirs_pkg::STEP_W;
  localparam logic [POSW-1:0]      POS_ONE = POSW'(lirs_pkg::ONE_Q16);
  localparam logic signed [YW-1:0] Y_ONE   = YW'(1 << (SW - 4));

  lirs_pkg::back_state_t           state_r, state_nxt;
  lirs_pkg::job_kind_t             kind_r;
  logic signed [SW-1:0]            y1_r, y2_r;
  logic signed [DW-1:0]            diff_r;
  logic [STW-1:0]                  eff_r;
  logic                            fin_r;
  logic [POSW-1:0]                 pos_r;
  logic [NW-1:0]                   cnt_r;
  logic [STW-1:0]                  read_pos_r;

  logic                            st_v_r, st_interp_r;
  logic signed [SW-1:0]            st_y1_r, st_val_r;
  logic signed [PW-1:0]            st_prod_r;
  logic                            st_holds_r, st_last_r, st_end_r;

  logic                            space_ok, issue, iss_interp, iss_holds, iss_last, iss_end;
  logic signed [SW-1:0]            iss_val;
  logic                            done;
  logic [STW-1:0]                  rp_nxt;
  logic [POSW-1:0]                 pos_step;
  logic                            in_range, step_over;
  logic signed [PW-1:0]            frac_x, diff_x;
  logic signed [PW-1:0]            rnd;
  logic signed [QW-1:0]            q;
  logic signed [YW-1:0]            y_full;

  // The stage register counts as in flight against the output queue space.
  assign space_ok  = (CW'(res_cnt) + CW'(st_v_r)) < CW'(lirs_pkg::OUT_DEPTH);
  assign pos_step  = pos_r + POSW'(eff_r);
  assign step_over = (pos_step >= POS_ONE);
  assign in_range  = (pos_r < POS_ONE) && (cnt_r < NW'(MAX_OUTPUTS_PER_INPUT));
  assign frac_x    = PW'($signed({1'b0, pos_r[lirs_pkg::FRAC_W-1:0]}));
  assign diff_x    = PW'(diff_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lirs_pkg::BK_IDLE: begin
        if (!job_empty) begin
          state_nxt = lirs_pkg::BK_RUN;
        end
      end
      lirs_pkg::BK_RUN: begin
        if (space_ok && done) begin
          state_nxt = lirs_pkg::BK_IDLE;
        end
      end
      default: state_nxt = lirs_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop    = 1'b0;
    issue      = 1'b0;
    iss_interp = 1'b0;
    iss_val    = '0;
    iss_holds  = 1'b1;
    iss_last   = 1'b0;
    iss_end    = 1'b0;
    done       = 1'b0;
    rp_nxt     = read_pos_r;
    case (state_r)
      lirs_pkg::BK_IDLE: begin
        job_pop = !job_empty;
      end
      lirs_pkg::BK_RUN: begin
        case (kind_r)
          lirs_pkg::JOB_PASS: begin
            issue    = space_ok;
            iss_val  = y2_r;
            iss_last = 1'b1;
            iss_end  = fin_r;
            done     = 1'b1;
            rp_nxt   = fin_r ? '0 : read_pos_r;
          end
          lirs_pkg::JOB_MARK: begin
            issue     = space_ok;
            iss_holds = 1'b0;
            iss_last  = 1'b1;
            iss_end   = 1'b1;
            done      = 1'b1;
            rp_nxt    = '0;
          end
          lirs_pkg::JOB_INTERP: begin
            if (in_range) begin
              issue      = space_ok;
              iss_interp = 1'b1;
              iss_last   = step_over || (cnt_r == NW'(MAX_OUTPUTS_PER_INPUT - 1));
              iss_end    = iss_last && fin_r;
              done       = iss_last;
              if (fin_r || !step_over) begin
                rp_nxt = '0;
              end else begin
                rp_nxt = STW'(pos_step - POS_ONE);
              end
            end else begin
              // Interval holds no read position: only an end marker can result.
              issue     = space_ok && fin_r;
              iss_holds = 1'b0;
              iss_last  = 1'b1;
              iss_end   = 1'b1;
              done      = 1'b1;
              if (fin_r || (pos_r < POS_ONE)) begin
                rp_nxt = '0;
              end else begin
                rp_nxt = STW'(pos_r - POS_ONE);
              end
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      default: begin
        job_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lirs_pkg::BK_IDLE;
      read_pos_r <= '0;
      st_v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_v_r  <= issue;
      if ((state_r == lirs_pkg::BK_RUN) && space_ok && done) begin
        read_pos_r <= rp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      kind_r <= job.kind;
      y1_r   <= job.y1;
      y2_r   <= job.y2;
      diff_r <= DW'(job.y2) - DW'(job.y1);
      eff_r  <= job.eff;
      fin_r  <= job.fin;
      pos_r  <= POSW'(read_pos_r);
      cnt_r  <= '0;
    end else if (issue && iss_interp) begin
      pos_r <= pos_step;
      cnt_r <= cnt_r + NW'(1);
    end
    if (issue) begin
      st_interp_r <= iss_interp;
      st_y1_r     <= y1_r;
      st_val_r    <= iss_val;
      st_prod_r   <= frac_x * diff_x;
      st_holds_r  <= iss_holds;
      st_last_r   <= iss_last;
      st_end_r    <= iss_end;
    end
  end

  // Round half up onto the sample grid, then zero anything beyond full scale.
  assign rnd    = st_prod_r + PW'(32768);
  assign q      = QW'(rnd >>> lirs_pkg::FRAC_W);
  assign y_full = YW'(st_y1_r) + YW'(q);

  always_comb begin
    res.holds_sample = st_holds_r;
    res.run_last     = st_last_r;
    res.stream_end   = st_end_r;
    if (!st_interp_r) begin
      res.sample_out = st_val_r;
    end else if ((y_full > Y_ONE) || (y_full < -Y_ONE)) begin
      res.sample_out = '0;
    end else begin
      res.sample_out = SW'(y_full);
    end
  end

  assign res_push = st_v_r;

endmodule

// File: src/linear_interp_resampler_unit.sv
// Linear-interpolation sample-rate converter. Each transfer on the input queue
// carries one signed Q4.20 sample; the unit keeps the previous sample and a
// Q5.16 read position and, for every position that falls between the previous
// and the new sample, delivers y1 + frac*(y2 - y1) rounded half up, or zero
// when that value lies beyond +/-1.0. The position advances by step_q16
// (written through cfg_wr_en/cfg_wr_data, reset value 1.0) after each result;
// steps below 1/MAX_OUTPUTS_PER_INPUT are raised to that value. A step of
// exactly 1.0 passes samples through unchanged. At other steps the first
// sample of a stream gives no result, and the final sample either tags its
// last result with stream_end or produces a single end marker with
// holds_sample low. The back end takes a job from the internal queue and
// then issues one result per clock, when not stalled, through a single
// shared multiplier; each result passes through the back end's stage
// register on its way into the output queue. The front end accepts a new
// sample every clock while the two-entry job queue has room, and the back
// end stalls only while the four-entry output queue together with the
// result held in its stage register accounts for four entries.
module linear_interp_resampler_unit #(
  parameter int MAX_OUTPUTS_PER_INPUT = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  lirs_pkg::lirs_in_t            in_data,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output lirs_pkg::lirs_out_t           out_data,
  input  logic                          cfg_wr_en,
  input  logic [lirs_pkg::STEP_W-1:0]   cfg_wr_data
);

  localparam int RCW = $clog2(lirs_pkg::OUT_DEPTH + 1);
  localparam int JCW = $clog2(lirs_pkg::JOB_DEPTH + 1);

  // Front end to job queue.
  logic                    job_push;
  lirs_pkg::lirs_job_t     job_wr;
  logic                    job_full;

  // Job queue to back end.
  lirs_pkg::lirs_job_t     job_rd;
  logic                    job_empty;
  logic                    job_pop;
  logic [JCW-1:0]          job_cnt;

  // Back end to output queue.
  logic                    res_push;
  lirs_pkg::lirs_out_t     res;
  logic                    res_full;
  logic [RCW-1:0]          res_cnt;

  // The front end owns the step register and the stored neighbor sample; it
  // turns every accepted sample into at most one job.
  lirs_front #(
    .MAX_OUTPUTS_PER_INPUT(MAX_OUTPUTS_PER_INPUT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_data    (in_data),
    .full       (full),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .job_push   (job_push),
    .job        (job_wr),
    .job_full   (job_full)
  );

  lirs_fifo #(
    .T    (lirs_pkg::lirs_job_t),
    .DEPTH(lirs_pkg::JOB_DEPTH)
  ) u_job_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_push),
    .wr_data(job_wr),
    .full   (job_full),
    .rd_en  (job_pop),
    .rd_data(job_rd),
    .empty  (job_empty),
    .count  (job_cnt)
  );

  // The back end owns the read position and walks it across each interval.
  lirs_back #(
    .MAX_OUTPUTS_PER_INPUT(MAX_OUTPUTS_PER_INPUT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job      (job_rd),
    .job_empty(job_empty),
    .job_pop  (job_pop),
    .res_cnt  (res_cnt),
    .res_push (res_push),
    .res      (res)
  );

  // Result queue; its head drives the output ports directly.
  lirs_fifo #(
    .T    (lirs_pkg::lirs_out_t),
    .DEPTH(lirs_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (res_push),
    .wr_data(res),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(out_data),
    .empty  (empty),
    .count  (res_cnt)
  );

`ifndef SYNTHESIS
  // The back end's space check must keep the result queue from overflowing.
  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result written into a full output queue");

  // A job is only produced for an accepted sample, never into a full queue.
  a_no_job_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> (push && !job_full))
    else $error("job written without an accepted input transfer");

  // The job queue can never report more entries than it holds.
  a_job_count: assert property (@(posedge clk) disable iff (!rst_n)
    job_cnt <= JCW'(lirs_pkg::JOB_DEPTH))
    else $error("job queue count out of range");

  // Reset leaves the output queue empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("output queue not empty after reset");
`endif

endmodule

// File: test/tb.sv
// Testbench for the linear-interpolation resampler. A directed table runs
// first, then random streams in phases, each with its own step setting and
// its own pattern of idle and stall cycles on the two queues. Every result
// that leaves the unit is compared with a typed-in result or with the
// output of a predictor kept in step with the accepted input samples.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_OUT   = 16;
  localparam int MIN_STEP  = (lirs_pkg::ONE_Q16 + MAX_OUT - 1) / MAX_OUT;
  localparam int STEP_MAX  = (1 << lirs_pkg::STEP_W) - 1;
  localparam longint AMP_ONE = longint'(1) << (lirs_pkg::SAMPLE_WIDTH - 4);
  localparam int S_MAX     = (1 << (lirs_pkg::SAMPLE_WIDTH - 1)) - 1;
  localparam int S_MIN     = -(1 << (lirs_pkg::SAMPLE_WIDTH - 1));
  // Cycles of silence that drain every job still inside the unit, including
  // jobs that produce no result: two queued jobs plus the back end at its
  // longest, plus the path through the stage register into the output queue.
  localparam int DRAIN     = 3 * (MAX_OUT + 4);
  localparam int LIMIT     = 4000;
  localparam int PHASES    = 16;
  localparam int PER_PHASE = 16;
  // A table row with this count is checked against the predictor.
  localparam int PREDICTED = -1;

  logic                          clk;
  logic                          rst_n;
  logic                          push;
  lirs_pkg::lirs_in_t            in_data;
  logic                          full;
  logic                          empty;
  logic                          pop = 1'b0;
  lirs_pkg::lirs_out_t           out_data;
  logic                          cfg_wr_en;
  logic [lirs_pkg::STEP_W-1:0]   cfg_wr_data;

  linear_interp_resampler_unit #(
    .MAX_OUTPUTS_PER_INPUT(MAX_OUT)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_data    (in_data),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Predictor state: the step register and the stream state of the unit.
  logic [lirs_pkg::STEP_W-1:0]              step_q16;
  logic signed [lirs_pkg::SAMPLE_WIDTH-1:0] prev_smp;
  logic                                     prev_valid;
  int unsigned                              read_pos;

  // Results still to arrive, oldest first, and the results of the last sample.
  lirs_pkg::lirs_out_t expected_out[$];
  lirs_pkg::lirs_out_t fresh_out[$];

  int err_count = 0;
  int quiet_cycles = 0;
  int send_idle_pct;
  int recv_stall_pct;
  lirs_pkg::lirs_out_t head;

  // One row of the directed table. A step change is written before the
  // sample goes in, with the unit idle.
  typedef struct {
    bit                  chg;
    int unsigned         stp;
    int                  smp;
    bit                  fin;
    int                  ntyped;
    lirs_pkg::lirs_out_t want;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic lirs_pkg::lirs_out_t result_of(input int s, input bit h, input bit l,
                                                    input bit e);
    lirs_pkg::lirs_out_t r;
    r.sample_out   = s;
    r.holds_sample = h;
    r.run_last     = l;
    r.stream_end   = e;
    return r;
  endfunction

  function automatic void clear_stream();
    prev_smp   = '0;
    prev_valid = 1'b0;
    read_pos   = 0;
  endfunction

  // y1 + frac*(y2 - y1), rounded half up; anything beyond +/-1.0 reads as zero.
  function automatic logic signed [lirs_pkg::SAMPLE_WIDTH-1:0] interp_point(
      input longint y1, input longint y2, input longint frac);
    longint prod;
    longint y;
    prod = frac * (y2 - y1);
    y = y1 + ((prod + 32768) >>> 16);
    if (y > AMP_ONE || y < -AMP_ONE) y = 0;
    return y[lirs_pkg::SAMPLE_WIDTH-1:0];
  endfunction

  // Works out every result that one accepted sample causes and advances the
  // stream state. The results land in fresh_out.
  function automatic void resample_predict(input lirs_pkg::lirs_in_t it);
    logic signed [lirs_pkg::SAMPLE_WIDTH-1:0] s;
    int unsigned eff;
    int unsigned pos;
    lirs_pkg::lirs_out_t r;
    int n;
    s = it.sample_in;
    n = 0;
    fresh_out.delete();
    if (step_q16 == lirs_pkg::ONE_Q16) begin
      // Unity step: straight pass-through, the read position is untouched.
      fresh_out.push_back(result_of(s, 1'b1, 1'b1, it.final_sample));
      prev_smp   = s;
      prev_valid = 1'b1;
      if (it.final_sample) clear_stream();
      return;
    end
    eff = (step_q16 < MIN_STEP) ? MIN_STEP : step_q16;
    if (prev_valid) begin
      pos = read_pos;
      while (pos < lirs_pkg::ONE_Q16 && n < MAX_OUT) begin
        r = result_of(interp_point(prev_smp, s, pos), 1'b1, 1'b0, 1'b0);
        fresh_out.push_back(r);
        n++;
        pos += eff;
      end
      if (pos >= lirs_pkg::ONE_Q16) pos -= lirs_pkg::ONE_Q16;
      else pos = 0;
      read_pos = pos & STEP_MAX;
    end
    prev_smp   = s;
    prev_valid = 1'b1;
    if (n > 0) begin
      r = fresh_out[n-1];
      r.run_last = 1'b1;
      if (it.final_sample) r.stream_end = 1'b1;
      fresh_out[n-1] = r;
    end else if (it.final_sample) begin
      // Nothing real came out of the last sample, so an end marker stands in.
      fresh_out.push_back(result_of(0, 1'b0, 1'b1, 1'b1));
    end
    if (it.final_sample) clear_stream();
  endfunction

  function automatic void add_row(input bit chg, input int unsigned stp, input int smp,
                                  input bit fin, input int ntyped,
                                  input lirs_pkg::lirs_out_t want);
    plan_row_t p;
    p.chg    = chg;
    p.stp    = stp;
    p.smp    = smp;
    p.fin    = fin;
    p.ntyped = ntyped;
    p.want   = want;
    plan.push_back(p);
  endfunction

  // Mostly audio reaching a little beyond +/-1.0, with full-scale noise and the field extremes mixed in.
  function automatic logic signed [lirs_pkg::SAMPLE_WIDTH-1:0] rand_sample();
    int v;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: v = S_MAX;
          1: v = S_MIN;
          2: v = 0;
          3: v = int'(AMP_ONE);
          default: v = -int'(AMP_ONE);
        endcase
      end
      default: v = int'($urandom_range(0, 2400000)) - 1200000;
    endcase
    return v[lirs_pkg::SAMPLE_WIDTH-1:0];
  endfunction

  // Presents one sample on the input queue, with random idle cycles ahead of
  // it, and holds it until the transfer happens. The expectation is then
  // either the predictor's output, the row's typed-in result or nothing.
  task automatic send_sample(input lirs_pkg::lirs_in_t it, input int ntyped,
                             input lirs_pkg::lirs_out_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push    = 1'b1;
    in_data = it;
    @(posedge clk);
    while (full) @(posedge clk);
    resample_predict(it);
    if (ntyped == PREDICTED) begin
      foreach (fresh_out[i]) expected_out.push_back(fresh_out[i]);
    end else if (ntyped > 0) begin
      expected_out.push_back(want);
    end
  endtask

  // Stops sending, lets every expected result come out, then waits long
  // enough for jobs that give no result to leave the unit as well.
  task automatic wait_quiet();
    @(negedge clk);
    push = 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_step(input int unsigned v);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v[lirs_pkg::STEP_W-1:0];
    step_q16    = v[lirs_pkg::STEP_W-1:0];
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // Result side: pop is chosen at the falling edge, the transfer is checked
  // at the rising edge.
  always @(negedge clk) begin
    pop <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_out.size() == 0) begin
        $error("result transfer with nothing expected: sample_out %0d", out_data.sample_out);
        err_count++;
      end else begin
        head = expected_out.pop_front();
        if (out_data.sample_out !== head.sample_out) begin
          $error("sample_out: expected %0d, got %0d", head.sample_out, out_data.sample_out);
          err_count++;
        end
        if (out_data.holds_sample !== head.holds_sample) begin
          $error("holds_sample: expected %0b, got %0b", head.holds_sample,
                 out_data.holds_sample);
          err_count++;
        end
        if (out_data.run_last !== head.run_last) begin
          $error("run_last: expected %0b, got %0b", head.run_last, out_data.run_last);
          err_count++;
        end
        if (out_data.stream_end !== head.stream_end) begin
          $error("stream_end: expected %0b, got %0b", head.stream_end, out_data.stream_end);
          err_count++;
        end
      end
    end
  end

  // Watchdog: a long run of cycles without any transfer means the unit hung.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || cfg_wr_en) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    lirs_pkg::lirs_in_t it;
    int unsigned        stp;
    int                 cnt;
    int                 len;

    push           = 1'b0;
    in_data        = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    rst_n          = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    step_q16       = lirs_pkg::ONE_Q16;
    clear_stream();

    // Directed table. At unity step the result is the input itself; away from
    // unity the first sample of a stream gives nothing; a final sample with no
    // real result gives an end marker.
    add_row(0, 0, S_MAX, 0, 1, result_of(S_MAX, 1, 1, 0));
    add_row(0, 0, S_MIN, 0, 1, result_of(S_MIN, 1, 1, 0));
    add_row(0, 0, 0, 1, 1, result_of(0, 1, 1, 1));
    // Half step: exact +/-1.0 survives, full-scale values clip to zero.
    add_row(1, 32768, int'(AMP_ONE), 0, 0, '0);
    add_row(0, 0, -int'(AMP_ONE), 0, PREDICTED, '0);
    add_row(0, 0, S_MAX, 0, PREDICTED, '0);
    add_row(0, 0, S_MIN, 0, PREDICTED, '0);
    add_row(0, 0, 100, 1, PREDICTED, '0);
    // Coarse steps: the read position runs past the new sample and the final
    // sample finds nothing to interpolate.
    add_row(1, 1048576, 5, 0, 0, '0);
    add_row(0, 0, 7, 0, PREDICTED, '0);
    add_row(0, 0, 9, 1, 1, result_of(0, 0, 1, 1));
    add_row(1, STEP_MAX, 1, 0, 0, '0);
    add_row(0, 0, 2, 0, PREDICTED, '0);
    add_row(0, 0, 3, 1, 1, result_of(0, 0, 1, 1));
    // Steps below the floor are raised to it and give the most results per sample.
    add_row(1, 1, int'(AMP_ONE) - 1, 0, 0, '0);
    add_row(0, 0, -int'(AMP_ONE) + 1, 0, PREDICTED, '0);
    add_row(1, MIN_STEP - 1, 0, 0, PREDICTED, '0);
    add_row(0, 0, int'(AMP_ONE), 1, PREDICTED, '0);
    // Just off unity, then unity in the middle of a stream.
    add_row(1, lirs_pkg::ONE_Q16 - 1, 12345, 0, 0, '0);
    add_row(1, lirs_pkg::ONE_Q16 + 1, -54321, 0, PREDICTED, '0);
    add_row(1, lirs_pkg::ONE_Q16, 4242, 0, 1, result_of(4242, 1, 1, 0));
    add_row(1, 32768, 0, 1, PREDICTED, '0);
    // Rounding of exact halves, up and toward zero.
    add_row(0, 0, 0, 0, 0, '0);
    add_row(0, 0, 1, 0, PREDICTED, '0);
    add_row(0, 0, 0, 0, PREDICTED, '0);
    add_row(0, 0, -1, 1, PREDICTED, '0);
    add_row(0, 0, 5, 1, 1, result_of(0, 0, 1, 1));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].chg) begin
        wait_quiet();
        write_step(plan[i].stp);
      end
      it.sample_in    = plan[i].smp;
      it.final_sample = plan[i].fin;
      send_sample(it, plan[i].ntyped, plan[i].want);
    end

    // Random phases. Each sets a step while the unit is idle and picks one
    // idle pattern: none, sparse input, slow reader, or light gaps on both.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_quiet();
      case (ph % 8)
        0: stp = lirs_pkg::ONE_Q16;
        1: stp = MIN_STEP;
        2: stp = STEP_MAX;
        3: stp = $urandom_range(0, MIN_STEP - 1);
        4: stp = 32768;
        5: stp = $urandom_range(MIN_STEP, 2 * lirs_pkg::ONE_Q16);
        6: stp = $urandom & STEP_MAX;
        default: stp = $urandom_range(lirs_pkg::ONE_Q16 - 2, lirs_pkg::ONE_Q16 + 2);
      endcase
      write_step(stp);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      // Streams of random length closed by a final sample; short streams and
      // stray final flags break the pattern now and then.
      cnt = 0;
      while (cnt < PER_PHASE) begin
        len = $urandom_range(1, 10);
        for (int k = 0; k < len && cnt < PER_PHASE; k++) begin
          it.sample_in    = rand_sample();
          it.final_sample = (k == len - 1) || ($urandom_range(0, 19) == 0);
          send_sample(it, PREDICTED, '0);
          cnt++;
        end
      end
    end

    @(negedge clk);
    push = 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
